// ===== src/smsrng_pkg.sv =====
// ----------------------------------------------------------------------------
// smsrng_pkg
// Shared constants, types and helpers for the shuffled minimal standard RNG.
// ----------------------------------------------------------------------------
package smsrng_pkg;

  localparam int DEF_TABLE_ENTRIES = 32;
  localparam int WARMUP_STEPS      = 8;

  localparam logic [14:0] LCG_MUL       = 15'd16807;
  localparam logic [30:0] LCG_MOD       = 31'h7FFF_FFFF;
  localparam logic [30:0] SEED_ONE      = 31'd1;
  localparam logic [30:0] CEILING_VALUE = 31'd2147483390;

  // Request opcodes
  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch request seed
    logic load_seed;   // generator state <= cleaned seed
    logic mul;         // product <= state * multiplier
    logic reduce;      // state <= product mod (2^31 - 1)
    logic fill_wr;     // write reduced value to table at fill index
    logic prime_last;  // last output <= reduced value
    logic div_init;    // slot select: last output * reciprocal of slot width
    logic draw_done;   // deliver table word, replace it, update last output
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic seeded;
  } dp_sts_t;

  // Mersenne reduction of a 46-bit product modulo 2^31 - 1.
  function automatic logic [30:0] lcg_reduce(input logic [45:0] p);
    logic [31:0] sum;
    logic [31:0] dif;
    sum = {1'b0, p[30:0]} + {17'b0, p[45:31]};
    dif = sum - {1'b0, LCG_MOD};
    lcg_reduce = (sum >= {1'b0, LCG_MOD}) ? dif[30:0] : sum[30:0];
  endfunction

  // Zero and the modulus itself are taken as 1.
  function automatic logic [30:0] seed_clean(input logic [30:0] s);
    seed_clean = (s == '0 || s == LCG_MOD) ? SEED_ONE : s;
  endfunction

endpackage

// ===== src/smsrng_ram.sv =====
// ----------------------------------------------------------------------------
// smsrng_ram
// Generic single-port RAM, registered read, read-before-write.
// ----------------------------------------------------------------------------
module smsrng_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = smsrng_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/smsrng_ctrl.sv =====
// ----------------------------------------------------------------------------
// smsrng_ctrl
// Sequencer: seeding (warmup + table fill) and the draw steps.
// ----------------------------------------------------------------------------
module smsrng_ctrl #(
  parameter int TABLE_ENTRIES = smsrng_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             op,
  input  smsrng_pkg::dp_sts_t              sts,
  output smsrng_pkg::ctl_cmd_t             cmd,
  output logic [$clog2(TABLE_ENTRIES)-1:0] fill_idx,
  output logic                             busy
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = (IDX_W > 3) ? IDX_W : 3;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_SEED = 10'b00_0000_0010,
    ST_WMUL = 10'b00_0000_0100,
    ST_WRED = 10'b00_0000_1000,
    ST_FMUL = 10'b00_0001_0000,
    ST_FRED = 10'b00_0010_0000,
    ST_DMUL = 10'b00_0100_0000,
    ST_DRED = 10'b00_1000_0000,
    ST_DRD  = 10'b01_0000_0000,
    ST_DOUT = 10'b10_0000_0000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = (op == smsrng_pkg::OP_RESEED || !sts.seeded) ? ST_SEED : ST_DMUL;
        end
      end
      ST_SEED: begin
        cmd.load_seed = 1'b1;
        cnt_next      = '0;
        state_next    = ST_WMUL;
      end
      ST_WMUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_WRED;
      end
      ST_WRED: begin
        cmd.reduce = 1'b1;
        if (cnt == CNT_W'(smsrng_pkg::WARMUP_STEPS - 1)) begin
          cnt_next   = CNT_W'(TABLE_ENTRIES - 1);
          state_next = ST_FMUL;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = ST_WMUL;
        end
      end
      ST_FMUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_FRED;
      end
      ST_FRED: begin
        cmd.reduce  = 1'b1;
        cmd.fill_wr = 1'b1;
        if (cnt == '0) begin
          cmd.prime_last = 1'b1;
          state_next     = ST_DMUL;
        end else begin
          cnt_next   = cnt - 1'b1;
          state_next = ST_FMUL;
        end
      end
      ST_DMUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DRED;
      end
      ST_DRED: begin
        cmd.reduce   = 1'b1;
        cmd.div_init = 1'b1;
        state_next   = ST_DRD;
      end
      ST_DRD: begin
        state_next = ST_DOUT;
      end
      ST_DOUT: begin
        cmd.draw_done = 1'b1;
        state_next    = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign fill_idx = cnt[IDX_W-1:0];
  assign busy     = (state != ST_IDLE);

endmodule

// ===== src/smsrng_dp.sv =====
// ----------------------------------------------------------------------------
// smsrng_dp
// Generator state, multiply/reduce, slot select, shuffle table, result regs.
// ----------------------------------------------------------------------------
module smsrng_dp #(
  parameter int TABLE_ENTRIES = smsrng_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             op,
  input  logic [30:0]                      seed_value,
  input  smsrng_pkg::ctl_cmd_t             cmd,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] fill_idx,
  output smsrng_pkg::dp_sts_t              sts,
  output logic [30:0]                      value,
  output logic                             at_ceiling,
  output logic                             done
);

  localparam int          IDX_W      = $clog2(TABLE_ENTRIES);
  localparam int unsigned SLOT_DIV   = 1 + 2147483646 / TABLE_ENTRIES;
  // floor(x / SLOT_DIV) == (x * RECIP) >> SLOT_SHIFT for every x below 2^31
  localparam int          SLOT_SH    = $clog2(SLOT_DIV);
  localparam int          SLOT_SHIFT = 31 + SLOT_SH;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << SLOT_SHIFT) + 64'(SLOT_DIV) - 64'd1) /
                                       64'(SLOT_DIV);
  localparam logic [32:0] RECIP      = RECIP_FULL[32:0];

  logic [30:0]      seed_q;
  logic [30:0]      lcg_state;
  logic [45:0]      prod;
  logic [30:0]      last_output;
  logic [63:0]      slot_prod;
  logic [IDX_W-1:0] quot;
  logic [30:0]      red;
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] ram_addr;
  logic [30:0]      ram_wdata;
  logic [30:0]      ram_rdata;
  logic             ram_we;

  assign red     = smsrng_pkg::lcg_reduce(prod);
  assign quot    = slot_prod[SLOT_SHIFT +: IDX_W];
  assign slot    = ({1'b0, quot} >= (IDX_W + 1)'(TABLE_ENTRIES)) ?
                   IDX_W'(TABLE_ENTRIES - 1) : quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state   <= smsrng_pkg::SEED_ONE;
      last_output <= '0;
      done        <= 1'b0;
    end else begin
      done <= cmd.draw_done;
      if (cmd.load_seed) begin
        lcg_state <= smsrng_pkg::seed_clean(seed_q);
      end else if (cmd.reduce) begin
        lcg_state <= red;
      end
      if (cmd.prime_last) begin
        last_output <= red;
      end else if (cmd.draw_done) begin
        last_output <= ram_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      seed_q <= (op == smsrng_pkg::OP_RESEED) ? seed_value : smsrng_pkg::SEED_ONE;
    end
    if (cmd.mul) begin
      prod <= {15'b0, lcg_state} * {31'b0, smsrng_pkg::LCG_MUL};
    end
    // slot = last output / slot width, by reciprocal multiply
    if (cmd.div_init) begin
      slot_prod <= {33'b0, last_output} * {31'b0, RECIP};
    end
    if (cmd.draw_done) begin
      value      <= ram_rdata;
      at_ceiling <= (ram_rdata >= smsrng_pkg::CEILING_VALUE);
    end
  end

  assign ram_we    = cmd.fill_wr || cmd.draw_done;
  assign ram_addr  = cmd.fill_wr ? fill_idx : slot;
  assign ram_wdata = cmd.fill_wr ? red : lcg_state;

  smsrng_ram #(
    .WIDTH (31),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign sts.seeded = (last_output != '0);

endmodule

// ===== src/shuffled_minimal_standard_rng_unit.sv =====
// ----------------------------------------------------------------------------
// shuffled_minimal_standard_rng_unit
// Park-Miller minimal standard generator (x16807 mod 2^31-1) behind a
// Bays-Durham shuffle table; one shuffled draw per request.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload             direction
//  request   start & !busy         op, seed_value      in
//  result    done (1-cycle pulse)  value, at_ceiling   out
//
//  Draw: one generator step through the 31x15 multiplier (multiply,
//  reduce), the slot select by a reciprocal multiply in the reduce cycle,
//  then a table read and a read-out/write.
//  Reseed (op = 1, or the first draw after reset) first adds a seed load,
//  8 warmup steps and one table fill step per entry, each multiply + reduce.
//  done pulses on the cycle busy drops; a new request can be taken then.
//  Reset is synchronous; the table is not cleared, every seeding fills it.
//  The receiver cannot stall: done marks each result for one cycle only.
//
module shuffled_minimal_standard_rng_unit #(
  parameter int TABLE_ENTRIES = smsrng_pkg::DEF_TABLE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        op,
  input  logic [30:0] seed_value,
  output logic        busy,
  output logic        done,
  output logic [30:0] value,
  output logic        at_ceiling
);

  smsrng_pkg::ctl_cmd_t             cmd;
  smsrng_pkg::dp_sts_t              sts;
  logic [$clog2(TABLE_ENTRIES)-1:0] fill_idx;

  // controller: seeding sequence and draw steps
  smsrng_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .op       (op),
    .sts      (sts),
    .cmd      (cmd),
    .fill_idx (fill_idx),
    .busy     (busy)
  );

  // datapath: generator, slot select, shuffle table, result registers
  smsrng_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .seed_value (seed_value),
    .cmd        (cmd),
    .fill_idx   (fill_idx),
    .sts        (sts),
    .value      (value),
    .at_ceiling (at_ceiling),
    .done       (done)
  );

  // ---- checks ----

  // one result per request, never on consecutive cycles
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back result strobes");

  // a result only comes from a seeded table and is never zero
  a_result_seeded: assert property (@(posedge clk) disable iff (rst)
    done |-> (sts.seeded && value != '0))
    else $error("result from unseeded generator or zero value");

  // an accepted request always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  // table writes happen only while busy
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.fill_wr || cmd.draw_done) |-> busy)
    else $error("table write while idle");

endmodule

// ===== tb/tb_shuffled_minimal_standard_rng_unit.sv =====
// ----------------------------------------------------------------------------
// tb_shuffled_minimal_standard_rng_unit
// Self-checking bench for the shuffled minimal standard RNG: directed
// reseed/draw requests, then ~1900 random requests, every draw compared
// against a local Lehmer + shuffle-table predictor.
// ----------------------------------------------------------------------------
module tb_shuffled_minimal_standard_rng_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Predictor geometry; the DUT runs with its default table size.
  localparam int          SHUFFLE_SLOTS = smsrng_pkg::DEF_TABLE_ENTRIES;
  localparam int unsigned SLOT_SPAN     = 1 + (int'(smsrng_pkg::LCG_MOD) - 1) / SHUFFLE_SLOTS;

  localparam int RANDOM_REQS  = 1900;
  localparam int QUIET_FIRST  = 600;   // random requests in this window never idle
  localparam int QUIET_LAST   = 999;
  localparam int DRAIN_PAUSE  = 1000;  // sender waits for all draws before this one
  localparam int TAIL_CYCLES  = 120;   // longer than the longest reseed + draw
  localparam int STALL_LIMIT  = 2000;  // cycles with neither accept nor done

  typedef struct packed {
    logic [30:0] value;
    logic        at_ceiling;
  } draw_t;

  typedef struct packed {
    logic        op;
    logic [30:0] seed;
  } request_t;

  logic        clk;
  logic        rst        = 1'b1;
  logic        start      = 1'b0;
  logic        op         = 1'b0;
  logic [30:0] seed_value = '0;
  logic        busy;
  logic        done;
  logic [30:0] value;
  logic        at_ceiling;

  // Predictor state
  logic [30:0] gen_state;
  logic [30:0] shuffle_words [SHUFFLE_SLOTS];
  logic [30:0] prev_draw;

  draw_t draws_due [$];
  int    error_count = 0;
  int    stall_cycles = 0;

  // Directed requests. No draw here has a value that can be read off by
  // eye, so every row goes through the predictor.
  localparam int DIRECTED_REQS = 18;
  request_t directed_reqs [DIRECTED_REQS] = '{
    '{smsrng_pkg::OP_DRAW,   31'h7FFF_FFFF},  // draw right after reset: implicit seed
    '{smsrng_pkg::OP_DRAW,   31'h0000_0000},  // seed field ignored on draw
    '{smsrng_pkg::OP_DRAW,   31'h5555_5555},
    '{smsrng_pkg::OP_RESEED, 31'd0},          // zero seed acts as one
    '{smsrng_pkg::OP_DRAW,   31'h2AAA_AAAA},
    '{smsrng_pkg::OP_RESEED, 31'd1},          // must repeat the zero-seed stream
    '{smsrng_pkg::OP_DRAW,   31'h0000_0000},
    '{smsrng_pkg::OP_RESEED, 31'h7FFF_FFFF},  // seed equal to the modulus acts as one
    '{smsrng_pkg::OP_DRAW,   31'h7FFF_FFFF},
    '{smsrng_pkg::OP_RESEED, 31'h7FFF_FFFE},  // largest legal seed
    '{smsrng_pkg::OP_DRAW,   31'h0000_0000},
    '{smsrng_pkg::OP_DRAW,   31'h0000_0000},
    '{smsrng_pkg::OP_RESEED, 31'h5555_5555},
    '{smsrng_pkg::OP_RESEED, 31'h2AAA_AAAA},  // back-to-back reseeds
    '{smsrng_pkg::OP_DRAW,   31'h1234_5678},
    '{smsrng_pkg::OP_RESEED, 31'd2},
    '{smsrng_pkg::OP_DRAW,   31'h0000_0000},
    '{smsrng_pkg::OP_DRAW,   31'h0000_0000}
  };

  shuffled_minimal_standard_rng_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .op         (op),
    .seed_value (seed_value),
    .busy       (busy),
    .done       (done),
    .value      (value),
    .at_ceiling (at_ceiling)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // One Lehmer step: s * 16807 mod (2^31 - 1), done in 64 bits.
  function automatic logic [30:0] minstd_next(input logic [30:0] s);
    logic [63:0] prod;
    prod = 64'(s) * 64'(smsrng_pkg::LCG_MUL);
    return 31'(prod % 64'(smsrng_pkg::LCG_MOD));
  endfunction

  // Seeding: clean the seed, 8 warmup steps, fill the table from the top
  // slot down, then prime the previous draw with slot 0.
  task automatic reseed_model(input logic [30:0] s);
    logic [30:0] cleaned;
    cleaned = (s == '0 || s == smsrng_pkg::LCG_MOD) ? smsrng_pkg::SEED_ONE : s;
    gen_state = cleaned;
    for (int i = 0; i < smsrng_pkg::WARMUP_STEPS; i++) gen_state = minstd_next(gen_state);
    for (int i = SHUFFLE_SLOTS - 1; i >= 0; i--) begin
      gen_state = minstd_next(gen_state);
      shuffle_words[i] = gen_state;
    end
    prev_draw = shuffle_words[0];
  endtask

  // Advance the predictor by one accepted request and queue its draw.
  task automatic predict_draw(input logic op_i, input logic [30:0] seed_i);
    int unsigned slot;
    draw_t       d;
    if (op_i == smsrng_pkg::OP_RESEED) reseed_model(seed_i);
    else if (prev_draw == '0) reseed_model(smsrng_pkg::SEED_ONE);  // never seeded yet
    gen_state = minstd_next(gen_state);
    slot = prev_draw / SLOT_SPAN;
    if (slot >= SHUFFLE_SLOTS) slot = SHUFFLE_SLOTS - 1;
    d.value      = shuffle_words[slot];
    d.at_ceiling = (shuffle_words[slot] >= smsrng_pkg::CEILING_VALUE);
    shuffle_words[slot] = gen_state;
    prev_draw = d.value;
    draws_due.push_back(d);
  endtask

  // Present a request at the falling edge and hold it until a rising edge
  // sees busy low; the predictor runs on that accept edge.
  task automatic issue_request(input logic op_i, input logic [30:0] seed_i);
    @(negedge clk);
    start      <= 1'b1;
    op         <= op_i;
    seed_value <= seed_i;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_draw(op_i, seed_i);
  endtask

  // Drop start for a stretch set by n; the payload carries junk meanwhile.
  task automatic idle_sender(input int n);
    @(negedge clk);
    start      <= 1'b0;
    op         <= 1'($urandom);
    seed_value <= 31'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  // Random seed, biased toward the special values.
  function automatic logic [30:0] pick_seed();
    unique case ($urandom_range(0, 9))
      0:       return '0;
      1:       return smsrng_pkg::LCG_MOD;
      2:       return smsrng_pkg::LCG_MOD - 31'd1;
      3:       return smsrng_pkg::SEED_ONE;
      default: return 31'($urandom);
    endcase
  endfunction

  // Draw checker: done is a single-cycle strobe, sampled on the rising edge.
  always @(posedge clk) begin
    draw_t exp_d;
    if (!rst && done) begin
      if (draws_due.size() == 0) begin
        $display("%0t: unexpected draw: value %0d at_ceiling %0b", $time, value, at_ceiling);
        error_count++;
      end else begin
        exp_d = draws_due.pop_front();
        if (value !== exp_d.value) begin
          $display("%0t: value mismatch: expected %0d, actual %0d",
                   $time, exp_d.value, value);
          error_count++;
        end
        if (at_ceiling !== exp_d.at_ceiling) begin
          $display("%0t: at_ceiling mismatch: expected %0b, actual %0b",
                   $time, exp_d.at_ceiling, at_ceiling);
          error_count++;
        end
      end
    end
  end

  // Watchdog: any accept or done clears the count.
  always @(posedge clk) begin
    if ((start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic rnd_op;
    bit   quiet;

    gen_state = smsrng_pkg::SEED_ONE;
    prev_draw = '0;
    foreach (shuffle_words[i]) shuffle_words[i] = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part
    for (int i = 0; i < DIRECTED_REQS; i++) begin
      issue_request(directed_reqs[i].op, directed_reqs[i].seed);
      if ($urandom_range(0, 99) < 22) idle_sender($urandom_range(1, 12));
    end

    // Let the block drain once before the random part.
    idle_sender(1);
    while (draws_due.size() != 0) @(posedge clk);

    // Random part: mostly draws, a few reseeds; gaps of varied length land
    // on every phase of the busy window.
    for (int i = 0; i < RANDOM_REQS; i++) begin
      quiet = (i >= QUIET_FIRST && i <= QUIET_LAST);
      if (i == DRAIN_PAUSE) begin
        idle_sender(1);
        while (draws_due.size() != 0) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 99) < 22) begin
        idle_sender($urandom_range(1, 12));
      end
      rnd_op = ($urandom_range(0, 99) < 5) ? smsrng_pkg::OP_RESEED : smsrng_pkg::OP_DRAW;
      issue_request(rnd_op,
                    (rnd_op == smsrng_pkg::OP_RESEED) ? pick_seed() : 31'($urandom));
    end

    // Wind down: wait for the last draw, then a quiet tail.
    idle_sender(1);
    while (draws_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && draws_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
